[hdl/binary_frame_receiver_fletcher_defines.svh]
// Assertion macros for the frame receiver parser module.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BINARY_FRAME_RECEIVER_FLETCHER_DEFINES_SVH
`define BINARY_FRAME_RECEIVER_FLETCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BFRF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BFRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/bfrf_pkg.sv]
// Package for the binary frame receiver: sync and acknowledge constants,
// the parser phase type and the result word type. Depends on nothing.
package bfrf_pkg;

   localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND     = 8'h62;
   localparam logic [7:0]  ACK_CLASS       = 8'h05;
   localparam logic [7:0]  ACK_ID_ACK      = 8'h01;
   localparam logic [7:0]  ACK_ID_REJECT   = 8'h00;
   localparam logic [15:0] DEFAULT_MAX_LEN = 16'd400;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN_LO  = 4'd4,
      PH_LEN_HI  = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CK_A    = 4'd7,
      PH_CK_B    = 4'd8
   } phase_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic        frame_end;
      logic        frame_good;
      logic [7:0]  frame_class;
      logic [7:0]  frame_id;
      logic [15:0] frame_length;
      logic        ack_valid;
      logic        ack_is_reject;
      logic [7:0]  acked_class;
      logic [7:0]  acked_id;
   } result_type;

endpackage

[hdl/binary_frame_receiver_fletcher.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  rx_byte
// rsp_      out        rsp_valid/rsp_stall  payload, frame end, header, acknowledgement
// csr_      in         csr_valid/csr_ready  max_payload_length
// One word in and one word out per cycle unless rsp_stall holds the pipe.
// The input register and the result register are the only stages; the parser sits between.
// Reset is synchronous and returns the parser to sync hunting with max length 400.
// A stalled result holds the pipe; the input register still takes a word while it is empty.
// Depends on bfrf_pkg and bfrf_parser.
module binary_frame_receiver_fletcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_index,
   output logic        rsp_frame_end,
   output logic        rsp_frame_good,
   output logic [7:0]  rsp_frame_class,
   output logic [7:0]  rsp_frame_id,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_ack_valid,
   output logic        rsp_ack_is_reject,
   output logic [7:0]  rsp_acked_class,
   output logic [7:0]  rsp_acked_id,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_payload_length
);
   import bfrf_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   result_type  result;
   logic [15:0] max_len_ff;
   logic        advance;
   logic        in_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_take   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= DEFAULT_MAX_LEN;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_payload_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   bfrf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .max_len (max_len_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_index = out_ff.payload_index;
   assign rsp_frame_end     = out_ff.frame_end;
   assign rsp_frame_good    = out_ff.frame_good;
   assign rsp_frame_class   = out_ff.frame_class;
   assign rsp_frame_id      = out_ff.frame_id;
   assign rsp_frame_length  = out_ff.frame_length;
   assign rsp_ack_valid     = out_ff.ack_valid;
   assign rsp_ack_is_reject = out_ff.ack_is_reject;
   assign rsp_acked_class   = out_ff.acked_class;
   assign rsp_acked_id      = out_ff.acked_id;

endmodule

[hdl/bfrf_parser.sv]
// Frame parser: phase machine, header registers and Fletcher sums.
// Depends on bfrf_pkg and the assertion macros in the defines header.
`include "binary_frame_receiver_fletcher_defines.svh"

module bfrf_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  logic [15:0]         max_len,
   output bfrf_pkg::result_type result
);
   import bfrf_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  check_lo_ff, check_lo_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [7:0]  add_a;
   logic [7:0]  add_b;
   logic [15:0] count_next;
   logic [15:0] new_length;
   logic        good;

   assign add_a      = sum_a_ff + rx_byte;
   assign add_b      = sum_b_ff + add_a;
   assign count_next = count_ff + 16'd1;
   assign new_length = {rx_byte, len_lo_ff};
   assign good       = (sum_a_ff == check_lo_ff) && (sum_b_ff == rx_byte);

   always_comb begin
      phase_in    = phase_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      len_lo_in   = len_lo_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      check_lo_in = check_lo_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      result      = '0;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SYNC_FIRST) begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (rx_byte == SYNC_SECOND) begin
               sum_a_in  = '0;
               sum_b_in  = '0;
               count_in  = '0;
               first_in  = '0;
               second_in = '0;
               phase_in  = PH_CLASS;
            end else if (rx_byte != SYNC_FIRST) begin
               phase_in = PH_HUNT;
            end
         end
         PH_CLASS: begin
            class_in = rx_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = rx_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_lo_in = rx_byte;
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            length_in = new_length;
            if (new_length > max_len) begin
               phase_in = PH_HUNT;
            end else if (new_length == 16'd0) begin
               phase_in = PH_CK_A;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = count_ff;
            if (count_ff == 16'd0) begin
               first_in = rx_byte;
            end else if (count_ff == 16'd1) begin
               second_in = rx_byte;
            end
            sum_a_in = add_a;
            sum_b_in = add_b;
            count_in = count_next;
            if (count_next >= length_ff) begin
               phase_in = PH_CK_A;
            end
         end
         PH_CK_A: begin
            check_lo_in = rx_byte;
            phase_in    = PH_CK_B;
         end
         PH_CK_B: begin
            result.frame_end  = 1'b1;
            result.frame_good = good;
            if (good && class_ff == ACK_CLASS &&
                (id_ff == ACK_ID_ACK || id_ff == ACK_ID_REJECT)) begin
               result.ack_valid     = 1'b1;
               result.ack_is_reject = (id_ff == ACK_ID_REJECT);
               result.acked_class   = first_ff;
               result.acked_id      = second_ff;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
      result.frame_class  = class_in;
      result.frame_id     = id_in;
      result.frame_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         class_ff    <= '0;
         id_ff       <= '0;
         len_lo_ff   <= '0;
         length_ff   <= '0;
         count_ff    <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         check_lo_ff <= '0;
         first_ff    <= '0;
         second_ff   <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         class_ff    <= class_in;
         id_ff       <= id_in;
         len_lo_ff   <= len_lo_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         check_lo_ff <= check_lo_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
      end
   end

   `BFRF_ASSERT_SAME(a_ack_needs_good, clock, reset, result.ack_valid,
      result.frame_good && result.frame_end && class_ff == ACK_CLASS, "ack on a bad frame")
   `BFRF_ASSERT_SAME(a_payload_not_end, clock, reset, result.payload_valid,
      !result.frame_end, "payload word flagged as frame end")
   `BFRF_ASSERT_NEXT(a_count_steps, clock, reset, step && phase_ff == PH_PAYLOAD,
      count_ff == 16'($past(count_ff) + 16'd1), "payload count did not advance")
   `BFRF_ASSERT_NEXT(a_long_dropped, clock, reset,
      step && phase_ff == PH_LEN_HI && new_length > max_len,
      phase_ff == PH_HUNT, "oversized frame not dropped")

endmodule
